@@ rtl/touch_gesture_classifier_top_assert.svh @@
// assertion macros for the touch gesture classifier
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// when a holds, b holds in the same cycle
`define TGC_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("tgc assertion failed");

// when a holds, b holds in the next cycle
`define TGC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("tgc assertion failed");

`else

`define TGC_ASSERT_IMPL(label, clk, rst_n, a, b)
`define TGC_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

@@ rtl/tgc_pkg.sv @@
package tgc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TICK_BITS_DEF  = 16;

	localparam int KIND_W  = 3;
	localparam int POS_W   = 16;
	localparam int VEC_W   = 17;
	localparam int CODE_W  = 2;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] SWIPE_DIST_RST = 16'd10;
	localparam logic [CFG_W-1:0] LONG_TAP_RST   = 16'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SWIPE_DIST = 1'b0,
		CFG_LONG_TAP   = 1'b1
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_BEGIN  = 3'd0,
		KIND_MOVE   = 3'd1,
		KIND_END    = 3'd2,
		KIND_CANCEL = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		GEST_TAP        = 2'd0,
		GEST_LONG_BEGIN = 2'd1,
		GEST_LONG_END   = 2'd2,
		GEST_SWIPE      = 2'd3
	} gest_t;

	typedef enum logic [CODE_W-1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		GS_NONE  = 2'd0,
		GS_LONG  = 2'd1,
		GS_SWIPE = 2'd2
	} gstate_t;

endpackage

@@ rtl/tgc_event_if.sv @@
interface tgc_event_if;
	import tgc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  delta_x;
	logic signed [POS_W-1:0]  delta_y;

	modport source (output valid, kind, pos_x, pos_y, delta_x, delta_y, input ready);
	modport sink (input valid, kind, pos_x, pos_y, delta_x, delta_y, output ready);
endinterface

@@ rtl/tgc_result_if.sv @@
interface tgc_result_if;
	import tgc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CODE_W-1:0]        gesture;
	logic [CODE_W-1:0]        direction;
	logic signed [VEC_W-1:0]  vec_x;
	logic signed [VEC_W-1:0]  vec_y;

	modport source (output valid, gesture, direction, vec_x, vec_y, input ready);
	modport sink (input valid, gesture, direction, vec_x, vec_y, output ready);
endinterface

@@ rtl/touch_gesture_classifier_top.sv @@
// an accepted item passes through the input stage and then the result register
// throughput: one item per cycle unless the result is stalled; the touch state is read and
//   updated as the item passes into the result register, so items follow back to back
// the input stage keeps moving while a finished result waits unless the result is stalled
// reset (arst_n low, asynchronous): no touch, no gesture, positions and tick count zero,
//   swipe distance 10, long-tap ticks 2, both stages empty
`include "touch_gesture_classifier_top_assert.svh"

module touch_gesture_classifier_top #(
	parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF,
	parameter int TICK_BITS  = tgc_pkg::TICK_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tgc_event_if.sink                        evt,
	tgc_result_if.source                     res,
	input  logic                             cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0]        cfg_data
);
	import tgc_pkg::*;

	// displacement width, compare width, and width for sign-extending to the result
	localparam int DW = COORD_BITS + 1;
	localparam int AW = (DW > CFG_W) ? DW : CFG_W;
	localparam int XW = (DW > VEC_W) ? DW : VEC_W;
	localparam int TW = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

	// configuration registers
	logic [CFG_W-1:0] swipe_dist_q;
	logic [CFG_W-1:0] long_tap_q;

	// input stage
	logic                         v_s1;
	logic [KIND_W-1:0]            kind_s1;
	logic signed [COORD_BITS-1:0] px_s1;
	logic signed [COORD_BITS-1:0] py_s1;
	logic signed [POS_W-1:0]      dlx_s1;
	logic signed [POS_W-1:0]      dly_s1;

	// touch state
	logic                         touched_q;
	gstate_t                      gstate_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic [TICK_BITS-1:0]         ticks_q;

	// result register
	logic                    out_valid_q;
	logic [CODE_W-1:0]       out_gest_q;
	logic [CODE_W-1:0]       out_dir_q;
	logic signed [VEC_W-1:0] out_vx_q;
	logic signed [VEC_W-1:0] out_vy_q;

	// next state
	logic                         touched_d;
	gstate_t                      gstate_d;
	logic signed [COORD_BITS-1:0] start_x_d;
	logic signed [COORD_BITS-1:0] start_y_d;
	logic signed [COORD_BITS-1:0] cur_x_d;
	logic signed [COORD_BITS-1:0] cur_y_d;
	logic [TICK_BITS-1:0]         ticks_d;

	// result of the item in the input stage
	logic                    hit;
	gest_t                   gest_c;
	dir_t                    dir_c;
	logic signed [VEC_W-1:0] vx_c;
	logic signed [VEC_W-1:0] vy_c;

	// datapath helpers
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [XW-1:0] dx_x;
	logic signed [XW-1:0] dy_x;
	logic signed [XW-1:0] cx_x;
	logic signed [XW-1:0] cy_x;
	logic [DW-1:0]        ax;
	logic [DW-1:0]        ay;
	logic [AW-1:0]        ax_w;
	logic [AW-1:0]        ay_w;
	logic [AW-1:0]        dist_w;
	logic                 x_dom;
	logic                 swipe_hit;
	logic [TICK_BITS-1:0] ticks_inc;
	logic                 long_hit;
	logic                 active;
	logic                 advance;

	// the input stage moves on whenever the result register can take its outcome
	assign advance   = !out_valid_q || res.ready;
	assign evt.ready = !v_s1 || advance;
	assign active    = touched_q && (gstate_q == GS_NONE);

	// swipe: displacement from the start, dominant axis, strict compare with the distance
	assign dx     = DW'(px_s1) - DW'(start_x_q);
	assign dy     = DW'(py_s1) - DW'(start_y_q);
	assign ax     = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay     = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign ax_w   = AW'(ax);
	assign ay_w   = AW'(ay);
	assign dist_w = AW'(swipe_dist_q);
	assign x_dom  = (ax_w >= ay_w);
	assign swipe_hit = x_dom ? (ax_w > dist_w) : (ay_w > dist_w);

	assign dx_x = XW'(dx);
	assign dy_x = XW'(dy);
	assign cx_x = XW'(cur_x_q);
	assign cy_x = XW'(cur_y_q);

	// tick count saturates at all ones
	assign ticks_inc = (ticks_q == {TICK_BITS{1'b1}}) ? ticks_q : ticks_q + 1'b1;
	assign long_hit  = (TW'(ticks_inc) > TW'(long_tap_q));

	// next state of the touch
	always_comb begin
		touched_d = touched_q;
		gstate_d  = gstate_q;
		start_x_d = start_x_q;
		start_y_d = start_y_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		ticks_d   = ticks_q;
		unique case (kind_s1)
			KIND_BEGIN: begin
				if (!touched_q) begin
					touched_d = 1'b1;
					gstate_d  = GS_NONE;
					start_x_d = px_s1;
					start_y_d = py_s1;
					cur_x_d   = px_s1;
					cur_y_d   = py_s1;
					ticks_d   = '0;
				end
			end
			KIND_MOVE: begin
				// a decided gesture freezes the position
				if (active) begin
					cur_x_d = px_s1;
					cur_y_d = py_s1;
					if (swipe_hit) begin
						gstate_d = GS_SWIPE;
					end
				end
			end
			KIND_END: begin
				if (touched_q) begin
					touched_d = 1'b0;
					gstate_d  = GS_NONE;
				end
			end
			KIND_CANCEL: begin
				// accepted in any state, also stops the tick count
				touched_d = 1'b0;
				gstate_d  = GS_NONE;
			end
			KIND_TICK: begin
				if (active) begin
					ticks_d = ticks_inc;
					if (long_hit) begin
						gstate_d = GS_LONG;
					end
				end
			end
			default: begin
				// undefined kinds leave the state alone
			end
		endcase
	end

	// result of the item
	always_comb begin
		hit    = 1'b0;
		gest_c = GEST_TAP;
		dir_c  = DIR_RIGHT;
		vx_c   = VEC_W'(dlx_s1);
		vy_c   = VEC_W'(dly_s1);
		unique case (kind_s1)
			KIND_MOVE: begin
				if (active && swipe_hit) begin
					hit    = 1'b1;
					gest_c = GEST_SWIPE;
					// zero on the dominant axis counts as right or up
					if (x_dom) begin
						dir_c = dx[DW-1] ? DIR_LEFT : DIR_RIGHT;
					end else begin
						dir_c = dy[DW-1] ? DIR_DOWN : DIR_UP;
					end
					vx_c = dx_x[VEC_W-1:0];
					vy_c = dy_x[VEC_W-1:0];
				end
			end
			KIND_END: begin
				// end after a swipe gives nothing
				if (touched_q && gstate_q == GS_NONE) begin
					hit    = 1'b1;
					gest_c = GEST_TAP;
				end else if (touched_q && gstate_q == GS_LONG) begin
					hit    = 1'b1;
					gest_c = GEST_LONG_END;
				end
			end
			KIND_TICK: begin
				if (active && long_hit) begin
					hit    = 1'b1;
					gest_c = GEST_LONG_BEGIN;
					vx_c   = cx_x[VEC_W-1:0];
					vy_c   = cy_x[VEC_W-1:0];
				end
			end
			default: begin
				// begin, cancel and undefined kinds give no result
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_dist_q <= SWIPE_DIST_RST;
			long_tap_q   <= LONG_TAP_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SWIPE_DIST) begin
				swipe_dist_q <= cfg_data;
			end else begin
				long_tap_q <= cfg_data;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1 <= evt.kind;
			px_s1   <= COORD_BITS'(evt.pos_x);
			py_s1   <= COORD_BITS'(evt.pos_y);
			dlx_s1  <= evt.delta_x;
			dly_s1  <= evt.delta_y;
		end
	end

	// touch state, updated as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= 1'b0;
			gstate_q  <= GS_NONE;
			start_x_q <= '0;
			start_y_q <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			ticks_q   <= '0;
		end else if (v_s1 && advance) begin
			touched_q <= touched_d;
			gstate_q  <= gstate_d;
			start_x_q <= start_x_d;
			start_y_q <= start_y_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			ticks_q   <= ticks_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1 && hit) begin
			out_gest_q <= gest_c;
			out_dir_q  <= dir_c;
			out_vx_q   <= vx_c;
			out_vy_q   <= vy_c;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.gesture   = out_gest_q;
	assign res.direction = out_dir_q;
	assign res.vec_x     = out_vx_q;
	assign res.vec_y     = out_vy_q;

	// a pending swipe or long-tap begin matches the gesture state it set
	`TGC_ASSERT_IMPL(a_swipe_state, clk, arst_n, out_valid_q && out_gest_q == GEST_SWIPE, gstate_q == GS_SWIPE)
	`TGC_ASSERT_IMPL(a_long_state, clk, arst_n, out_valid_q && out_gest_q == GEST_LONG_BEGIN, gstate_q == GS_LONG && touched_q)
	// a tap or long-tap end releases the touch
	`TGC_ASSERT_IMPL(a_end_release, clk, arst_n, out_valid_q && (out_gest_q == GEST_TAP || out_gest_q == GEST_LONG_END), !touched_q)
	// a decided gesture needs a touch
	`TGC_ASSERT_IMPL(a_gest_touch, clk, arst_n, gstate_q != GS_NONE, touched_q)
	// only a swipe carries a direction
	`TGC_ASSERT_IMPL(a_dir_swipe, clk, arst_n, out_valid_q && out_dir_q != DIR_RIGHT, out_gest_q == GEST_SWIPE)

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int DRAIN_TAIL    = 4;     // pipeline tail plus margin
	localparam int STALL_LIMIT   = 1000;  // cycles without any handshake before giving up
	localparam int REPORT_MAX    = 10;
	localparam int SEGMENT_ITEMS = 90;
	localparam int HOLD_CYCLES   = 120;
	localparam int TICK_W        = TICK_BITS_DEF;

	// one gesture report as it leaves the block
	typedef struct packed {
		gest_t                   gesture;
		dir_t                    direction;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
	} gesture_rec_t;

	// one row of the directed table; typed rows carry their own expected report
	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] dlx;
		logic signed [POS_W-1:0] dly;
		bit                      typed;
		bit                      hit;
		gesture_rec_t            want;
	} stim_row_t;

	localparam gesture_rec_t NO_GESTURE = '{GEST_TAP, DIR_RIGHT, 17'sd0, 17'sd0};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tgc_event_if  evt();
	tgc_result_if res();

	touch_gesture_classifier_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the recognizer state and its registers
	logic [CFG_W-1:0]        swipe_dist_q = SWIPE_DIST_RST;
	logic [CFG_W-1:0]        long_tap_q   = LONG_TAP_RST;
	bit                      touch_down   = 1'b0;
	gstate_t                 gest_state   = GS_NONE;
	logic signed [POS_W-1:0] start_x      = '0;
	logic signed [POS_W-1:0] start_y      = '0;
	logic signed [POS_W-1:0] cur_x        = '0;
	logic signed [POS_W-1:0] cur_y        = '0;
	logic [TICK_W-1:0]       tick_count   = '0;

	// reports still owed by the block, oldest first
	gesture_rec_t pending_gestures [$];

	int mismatch_count = 0;
	int idle_send_pct  = 0;
	int idle_recv_pct  = 0;
	int hold_request   = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	// directed table: the extremes and each special case, reset thresholds (10, 2)
	stim_row_t directed_rows [26] = '{
		// nothing touched yet: move, end and tick are ignored
		'{KIND_MOVE,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_END,    16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_TICK,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_BEGIN,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// second begin while touched is dropped
		'{KIND_BEGIN,  16'sd5, 16'sd5, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// exactly at the threshold is not a swipe
		'{KIND_MOVE,   16'sd10, -16'sd10, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// equal magnitudes, x axis wins
		'{KIND_MOVE,   -16'sd11, 16'sd11, 16'sd0, 16'sd0, 1'b1, 1'b1,
			'{GEST_SWIPE, DIR_LEFT, -17'sd11, 17'sd11}},
		// gesture decided: move ignored
		'{KIND_MOVE,   16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// end after a swipe releases silently
		'{KIND_END,    16'sd0, 16'sd0, 16'sd7, 16'sd7, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_BEGIN,  16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_TICK,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_TICK,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// third tick exceeds two: long tap begin at the current corner
		'{KIND_TICK,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1,
			'{GEST_LONG_BEGIN, DIR_RIGHT, 17'sd32767, -17'sd32768}},
		// counting stopped, moves frozen
		'{KIND_TICK,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_MOVE,   16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_END,    16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 1'b1, 1'b1,
			'{GEST_LONG_END, DIR_RIGHT, -17'sd32768, 17'sd32767}},
		// corner to corner: widest displacement
		'{KIND_BEGIN,  16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_MOVE,   16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b1, 1'b1,
			'{GEST_SWIPE, DIR_RIGHT, 17'sd65535, 17'sd0}},
		// cancel in a decided state, then end finds nothing touched
		'{KIND_CANCEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_END,    16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		'{KIND_BEGIN,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// y axis dominant, negative
		'{KIND_MOVE,   16'sd3, -16'sd11, 16'sd0, 16'sd0, 1'b1, 1'b1,
			'{GEST_SWIPE, DIR_DOWN, 17'sd3, -17'sd11}},
		'{KIND_CANCEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0, NO_GESTURE},
		// short touch: small move left to the predictor, then a tap
		'{KIND_BEGIN,  16'sd1, 16'sd2, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_GESTURE},
		'{KIND_MOVE,   16'sd4, 16'sd6, 16'sd0, 16'sd0, 1'b0, 1'b0, NO_GESTURE},
		'{KIND_END,    16'sd0, 16'sd0, 16'sd3, -16'sd4, 1'b1, 1'b1,
			'{GEST_TAP, DIR_RIGHT, 17'sd3, -17'sd4}}
	};

	// advance the shadow recognizer by one event, returns 1 when it reports a gesture
	function automatic bit predict_gesture(input logic [KIND_W-1:0] kind,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [POS_W-1:0] dlx, input logic signed [POS_W-1:0] dly,
			output gesture_rec_t g);
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		logic [VEC_W-1:0]        ax;
		logic [VEC_W-1:0]        ay;
		bit                      hit;
		hit = 1'b0;
		g = NO_GESTURE;
		case (kind)
			KIND_BEGIN: begin
				if (!touch_down) begin
					touch_down = 1'b1;
					gest_state = GS_NONE;
					start_x    = px;
					start_y    = py;
					cur_x      = px;
					cur_y      = py;
					tick_count = '0;
				end
			end
			KIND_MOVE: begin
				if (touch_down && gest_state == GS_NONE) begin
					cur_x = px;
					cur_y = py;
					dx = {cur_x[POS_W-1], cur_x} - {start_x[POS_W-1], start_x};
					dy = {cur_y[POS_W-1], cur_y} - {start_y[POS_W-1], start_y};
					ax = dx[VEC_W-1] ? -dx : dx;
					ay = dy[VEC_W-1] ? -dy : dy;
					// ties go to the x axis
					if (ax >= ay) begin
						if (ax > {1'b0, swipe_dist_q}) begin
							hit = 1'b1;
							g.direction = dx[VEC_W-1] ? DIR_LEFT : DIR_RIGHT;
						end
					end else if (ay > {1'b0, swipe_dist_q}) begin
						hit = 1'b1;
						g.direction = dy[VEC_W-1] ? DIR_DOWN : DIR_UP;
					end
					if (hit) begin
						gest_state = GS_SWIPE;
						g.gesture  = GEST_SWIPE;
						g.vec_x    = dx;
						g.vec_y    = dy;
					end
				end
			end
			KIND_END: begin
				if (touch_down) begin
					if (gest_state == GS_NONE) begin
						hit = 1'b1;
						g.gesture = GEST_TAP;
					end else if (gest_state == GS_LONG) begin
						hit = 1'b1;
						g.gesture = GEST_LONG_END;
					end
					g.vec_x    = {dlx[POS_W-1], dlx};
					g.vec_y    = {dly[POS_W-1], dly};
					gest_state = GS_NONE;
					touch_down = 1'b0;
				end
			end
			KIND_CANCEL: begin
				touch_down = 1'b0;
				gest_state = GS_NONE;
			end
			KIND_TICK: begin
				if (touch_down && gest_state == GS_NONE) begin
					// count saturates at all ones
					if (tick_count != '1)
						tick_count = tick_count + 1'b1;
					if (tick_count > long_tap_q) begin
						hit        = 1'b1;
						gest_state = GS_LONG;
						g.gesture  = GEST_LONG_BEGIN;
						g.vec_x    = {cur_x[POS_W-1], cur_x};
						g.vec_y    = {cur_y[POS_W-1], cur_y};
					end
				end
			end
			default: ;
		endcase
		if (!hit)
			g = NO_GESTURE;
		return hit;
	endfunction

	function automatic logic signed [POS_W-1:0] rand_pos();
		return POS_W'($urandom);
	endfunction

	// offer one item, with random idle cycles first, and return at the accepting edge
	task automatic offer_event(input logic [KIND_W-1:0] kind,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [POS_W-1:0] dlx, input logic signed [POS_W-1:0] dly);
		while ($urandom_range(0, 99) < idle_send_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid   <= 1'b1;
		evt.kind    <= kind;
		evt.pos_x   <= px;
		evt.pos_y   <= py;
		evt.delta_x <= dlx;
		evt.delta_y <= dly;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
	endtask

	// offer an item and queue whatever the shadow recognizer says it causes
	task automatic send_event(input logic [KIND_W-1:0] kind,
			input logic signed [POS_W-1:0] px, input logic signed [POS_W-1:0] py,
			input logic signed [POS_W-1:0] dlx, input logic signed [POS_W-1:0] dly);
		gesture_rec_t g;
		offer_event(kind, px, py, dlx, dly);
		if (predict_gesture(kind, px, py, dlx, dly, g))
			pending_gestures.push_back(g);
	endtask

	// stop offering, wait out every owed report and the pipeline tail
	task automatic drain_results();
		evt.valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic write_config(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SWIPE_DIST: swipe_dist_q = value;
			default:        long_tap_q   = value;
		endcase
	endtask

	// one touch from begin to release, with occasional pure noise instead
	task automatic run_touch_sequence(inout int counted);
		logic signed [POS_W-1:0] sx;
		logic signed [POS_W-1:0] sy;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		int  lim;
		int  off_x;
		int  off_y;
		bit  corner;
		if ($urandom_range(0, 9) == 0) begin
			// noise: any kind, reserved codes included
			send_event(KIND_W'($urandom_range(0, 7)), rand_pos(), rand_pos(), rand_pos(),
				rand_pos());
			counted++;
			return;
		end
		lim = int'(swipe_dist_q) + 3;
		corner = ($urandom_range(0, 11) == 0);
		if (corner) begin
			sx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			sy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		end else begin
			sx = rand_pos();
			sy = rand_pos();
		end
		send_event(KIND_BEGIN, sx, sy, rand_pos(), rand_pos());
		counted++;
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 3))
				0: send_event(KIND_TICK, rand_pos(), rand_pos(), rand_pos(), rand_pos());
				1: begin
					// burst just long enough to cross a small long-tap threshold
					if (long_tap_q < 16) begin
						repeat (int'(long_tap_q) + 1)
							send_event(KIND_TICK, rand_pos(), rand_pos(), rand_pos(), rand_pos());
						counted += int'(long_tap_q);
					end else
						send_event(KIND_TICK, rand_pos(), rand_pos(), rand_pos(), rand_pos());
				end
				default: begin
					if (corner) begin
						// jump to the opposite corner or stay
						px = $urandom_range(0, 1) ? ~sx : sx;
						py = $urandom_range(0, 1) ? ~sy : sy;
					end else begin
						// offsets straddle the swipe threshold
						off_x = int'($urandom_range(0, 2 * lim)) - lim;
						off_y = int'($urandom_range(0, 2 * lim)) - lim;
						if ($urandom_range(0, 5) == 0)
							off_y = $urandom_range(0, 1) ? off_x : -off_x;
						px = sx + POS_W'(off_x);
						py = sy + POS_W'(off_y);
					end
					send_event(KIND_MOVE, px, py, rand_pos(), rand_pos());
				end
			endcase
			counted++;
		end
		case ($urandom_range(0, 9))
			0, 1: send_event(KIND_CANCEL, rand_pos(), rand_pos(), rand_pos(), rand_pos());
			2: begin
				// stray begin while still touched, then release
				send_event(KIND_BEGIN, rand_pos(), rand_pos(), rand_pos(), rand_pos());
				send_event(KIND_END, rand_pos(), rand_pos(), rand_pos(), rand_pos());
				counted++;
			end
			default: send_event(KIND_END, rand_pos(), rand_pos(), rand_pos(), rand_pos());
		endcase
		counted++;
	endtask

	// one threshold setting, three idling patterns, one long output stall
	task automatic run_phase(input logic [CFG_W-1:0] swipe_val, input logic [CFG_W-1:0] long_val);
		int counted;
		write_config(CFG_SWIPE_DIST, swipe_val);
		write_config(CFG_LONG_TAP, long_val);
		for (int seg = 0; seg < 3; seg++) begin
			if (seg == 0) begin
				idle_send_pct = 14;
				idle_recv_pct = 70;
				// receiver holds off while items keep coming, so the block backs up
				hold_request = HOLD_CYCLES;
			end else if (seg == 1) begin
				idle_send_pct = 70;
				idle_recv_pct = 14;
			end else begin
				idle_send_pct = 0;
				idle_recv_pct = 0;
			end
			counted = 0;
			while (counted < SEGMENT_ITEMS)
				run_touch_sequence(counted);
			// sender pauses until every owed report is out
			if (seg == 1)
				drain_results();
		end
	endtask

	// compare one accepted report with the oldest owed one
	task automatic check_gesture(input gesture_rec_t got);
		gesture_rec_t want;
		if (pending_gestures.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected gesture %0d dir %0d vec (%0d, %0d)", got.gesture,
					got.direction, got.vec_x, got.vec_y);
			return;
		end
		want = pending_gestures.pop_front();
		if (got.gesture !== want.gesture || got.direction !== want.direction ||
				got.vec_x !== want.vec_x || got.vec_y !== want.vec_y) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("gesture mismatch: expected %0d dir %0d vec (%0d, %0d), got %0d dir %0d vec (%0d, %0d)",
					want.gesture, want.direction, want.vec_x, want.vec_y,
					got.gesture, got.direction, got.vec_x, got.vec_y);
		end
	endtask

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off counted here on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request > 0) begin
			res.ready    <= 1'b0;
			hold_left    <= hold_request;
			hold_request = 0;
		end else begin
			res.ready <= ($urandom_range(0, 99) >= idle_recv_pct);
		end
	end

	// result monitor, samples the values from before the edge
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			check_gesture('{gest_t'(res.gesture), dir_t'(res.direction), res.vec_x, res.vec_y});
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (evt.valid && evt.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** touch_gesture_classifier_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// main sequence
	initial begin
		gesture_rec_t g;
		bit           row_hit;
		evt.valid   = 1'b0;
		evt.kind    = KIND_BEGIN;
		evt.pos_x   = '0;
		evt.pos_y   = '0;
		evt.delta_x = '0;
		evt.delta_y = '0;
		res.ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_SWIPE_DIST;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset thresholds
		idle_send_pct = 14;
		idle_recv_pct = 70;
		foreach (directed_rows[i]) begin
			offer_event(directed_rows[i].kind, directed_rows[i].px, directed_rows[i].py,
				directed_rows[i].dlx, directed_rows[i].dly);
			row_hit = predict_gesture(directed_rows[i].kind, directed_rows[i].px,
				directed_rows[i].py, directed_rows[i].dlx, directed_rows[i].dly, g);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].hit)
					pending_gestures.push_back(directed_rows[i].want);
			end else if (row_hit) begin
				pending_gestures.push_back(g);
			end
		end

		// random touches over several threshold settings, zero and all ones among them
		run_phase(SWIPE_DIST_RST, LONG_TAP_RST);
		run_phase('0, '0);
		run_phase(16'd1, 16'd1);
		run_phase(16'hffff, 16'hffff);
		run_phase(CFG_W'($urandom_range(2, 2000)), CFG_W'($urandom_range(3, 12)));
		run_phase(16'hfffe, 16'd4);

		drain_results();
		if (mismatch_count == 0 && pending_gestures.size() == 0)
			$display("** touch_gesture_classifier_top: PASSED **");
		else
			$display("** touch_gesture_classifier_top: FAILED **");
		$finish;
	end

endmodule

@@ touch_gesture_classifier_top.f @@
+incdir+rtl
rtl/tgc_pkg.sv
rtl/tgc_event_if.sv
rtl/tgc_result_if.sv
rtl/touch_gesture_classifier_top.sv
tb/testbench.sv
